// ===== rtl/core/rdeq_pkg.sv =====
// shared constants and codes for the reversible double-ended queue
package rdeq_pkg;

   localparam int DEPTH      = 1024;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_TAKE_FRONT = 3'd2,
      ACT_TAKE_BACK  = 3'd3,
      ACT_REVERSE    = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_TAKEN = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

endpackage

// ===== rtl/core/reversible_double_ended_queue_top.sv =====
// reversible double-ended queue: ring buffer in a synchronous ram plus head, count and flag
// result: push, reverse, refused and empty-take items give a registered result; a take with data
// is first read into the ram read register and then loaded into the result register.
// throughput: one item per cycle while rsp_ready takes each result, except that a take with data
// holds off the next item while its read completes.
// reset: synchronous, clears head, count, reverse flag and handshake state; ram is not cleared.
module reversible_double_ended_queue_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_action,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic signed [31:0]          rsp_taken_value
);

   logic [rdeq_pkg::VALUE_BITS-1:0] mem [rdeq_pkg::DEPTH];

   logic [rdeq_pkg::ADDR_W-1:0]     head_ff, head_in;
   logic [rdeq_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic                            reversed_ff, reversed_in;
   logic                            pending_ff, pending_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      rsp_status_ff, rsp_status_in;
   logic [31:0]                     rsp_value_ff, rsp_value_in;
   logic [rdeq_pkg::VALUE_BITS-1:0] rd_data_ff;

   logic                            accept;
   logic                            phys_back;
   logic                            is_full;
   logic                            is_empty;
   logic                            mem_we;
   logic                            mem_re;
   logic [rdeq_pkg::ADDR_W-1:0]     head_dec;
   logic [rdeq_pkg::ADDR_W-1:0]     head_inc;
   logic [rdeq_pkg::ADDR_W-1:0]     tail_pos;
   logic [rdeq_pkg::ADDR_W-1:0]     back_pos;
   logic [rdeq_pkg::ADDR_W-1:0]     mem_addr;
   logic [rdeq_pkg::COUNT_W:0]      tail_sum;
   logic [rdeq_pkg::COUNT_W:0]      back_sum;

   assign req_ready       = !pending_ff && (!rsp_valid_ff || rsp_ready);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_taken_value = rsp_value_ff;

   assign is_full  = (count_ff == rdeq_pkg::COUNT_W'(rdeq_pkg::DEPTH));
   assign is_empty = (count_ff == '0);

   // ring position arithmetic
   always_comb begin
      tail_sum = (rdeq_pkg::COUNT_W+1)'(head_ff) + (rdeq_pkg::COUNT_W+1)'(count_ff);
      if (tail_sum >= (rdeq_pkg::COUNT_W+1)'(rdeq_pkg::DEPTH))
         tail_sum = tail_sum - (rdeq_pkg::COUNT_W+1)'(rdeq_pkg::DEPTH);
      tail_pos = tail_sum[rdeq_pkg::ADDR_W-1:0];
      // back = head + count - 1, wrapped; only used when count is nonzero
      back_sum = (rdeq_pkg::COUNT_W+1)'(head_ff) + (rdeq_pkg::COUNT_W+1)'(count_ff)
               - (rdeq_pkg::COUNT_W+1)'(1);
      if (back_sum >= (rdeq_pkg::COUNT_W+1)'(rdeq_pkg::DEPTH))
         back_sum = back_sum - (rdeq_pkg::COUNT_W+1)'(rdeq_pkg::DEPTH);
      back_pos = back_sum[rdeq_pkg::ADDR_W-1:0];
      if (head_ff == rdeq_pkg::ADDR_W'(rdeq_pkg::DEPTH - 1))
         head_inc = '0;
      else
         head_inc = head_ff + rdeq_pkg::ADDR_W'(1);
      if (head_ff == '0)
         head_dec = rdeq_pkg::ADDR_W'(rdeq_pkg::DEPTH - 1);
      else
         head_dec = head_ff - rdeq_pkg::ADDR_W'(1);
   end

   // decode one item: state update, ram access and result, or the ram read data of a pending take
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      reversed_in   = reversed_ff;
      pending_in    = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = head_ff;
      phys_back     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;

      if (pending_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rdeq_pkg::ST_TAKEN;
         rsp_value_in  = 32'(signed'(rd_data_ff));
      end

      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rdeq_pkg::ST_DONE;
         rsp_value_in  = '0;
         case (req_action)
            rdeq_pkg::ACT_PUSH_FRONT,
            rdeq_pkg::ACT_PUSH_BACK: begin
               phys_back = (req_action == rdeq_pkg::ACT_PUSH_BACK) ^ reversed_ff;
               if (is_full) begin
                  rsp_status_in = rdeq_pkg::ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + rdeq_pkg::COUNT_W'(1);
                  if (phys_back) begin
                     mem_addr = tail_pos;
                  end else begin
                     mem_addr = head_dec;
                     head_in  = head_dec;
                  end
               end
            end
            rdeq_pkg::ACT_TAKE_FRONT,
            rdeq_pkg::ACT_TAKE_BACK: begin
               phys_back = (req_action == rdeq_pkg::ACT_TAKE_BACK) ^ reversed_ff;
               if (is_empty) begin
                  rsp_status_in = rdeq_pkg::ST_EMPTY;
               end else begin
                  // result is loaded next cycle from the ram read data
                  mem_re       = 1'b1;
                  pending_in   = 1'b1;
                  rsp_valid_in = 1'b0;
                  count_in     = count_ff - rdeq_pkg::COUNT_W'(1);
                  if (phys_back) begin
                     mem_addr = back_pos;
                  end else begin
                     mem_addr = head_ff;
                     head_in  = head_inc;
                  end
               end
            end
            rdeq_pkg::ACT_REVERSE: begin
               reversed_in = !reversed_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_addr] <= req_value[rdeq_pkg::VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_re)
         rd_data_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         reversed_ff  <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         reversed_ff  <= reversed_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

endmodule
